[src/tpra_pkg.sv]
`default_nettype none

package tpra_pkg;

    // Fixed field widths.
    localparam int TIME_W      = 32;
    localparam int RPM_W       = 16;

    // Revolutions per minute from a period in microseconds: 60000000 / period.
    localparam int RPM_NUM_W   = 26;
    localparam logic [RPM_NUM_W-1:0] RPM_NUMERATOR = 26'd60000000;
    localparam logic [RPM_W-1:0]     RPM_MAX       = 16'hFFFF;

    // Reset value of the stall timeout.
    localparam logic [TIME_W-1:0] STALL_RESET = 32'd600000;

    localparam int RING_DEPTH_DEFAULT = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SEL,
        S_QDIV,
        S_UPDATE,
        S_ASTART,
        S_ADIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

[src/tpra_div.sv]
`default_nettype none

module tpra_div #(
    parameter int NUM_W = tpra_pkg::RPM_NUM_W
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [NUM_W-1:0]          i_num,
    input  wire logic [tpra_pkg::TIME_W-1:0] i_den,
    output tpra_pkg::t_div_status          o_status,
    output logic [NUM_W-1:0]               o_quot
);
    import tpra_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of r_num while quotient bits shift in at the bottom.
    logic [NUM_W-1:0]  r_num;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TIME_W:0]   w_trial;
    logic [TIME_W:0]   w_diff;
    logic              w_fits;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_fits};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_num;

endmodule

`default_nettype wire

[src/tpra_ring.sv]
`default_nettype none

module tpra_ring #(
    parameter int RING_DEPTH = tpra_pkg::RING_DEPTH_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd,
    input  wire logic                       i_wr,
    input  wire logic [tpra_pkg::RPM_W-1:0] i_wr_data,
    output logic [tpra_pkg::RPM_W-1:0]      o_rd_data
);
    import tpra_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [RPM_W-1:0]      r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]      r_idx;
    logic [RPM_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    // Both the read and the write use the current position; the position
    // moves on after each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
        end else if (i_wr) begin
            r_valid[r_idx] <= 1'b1;
            if (r_idx == IDX_W'(RING_DEPTH - 1)) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_idx] <= i_wr_data;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_vld  <= r_valid[r_idx];
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(RING_DEPTH - 1))
        else $error("ring position beyond depth");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_wr |=> $stable(r_idx))
        else $error("ring position moved without a write");

    a_valid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |=> r_valid[$past(r_idx)])
        else $error("written entry not marked valid");

endmodule

`default_nettype wire

[src/tachometer_period_to_rpm_average.sv]
// Period tachometer with a moving average of speed.
// Input channel (i_s_*): one item per speed update, carrying the current
// microsecond time and the timestamps of the last two pulses. Output channel
// (o_m_*): one item per update with the new average, the instant speed and
// a stall flag. The stall timeout is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
// The instant speed comes from a bit-serial restoring divider that produces
// one quotient bit per cycle over a 26-bit dividend, and the same divider
// then divides the running ring sum by the ring depth. An accepted update
// goes through the states PREP, SEL, QDIV, UPDATE, ASTART, ADIV and OUT;
// when the stall timeout or a zero period settles the instant speed, the
// first division (QDIV) is skipped. One item is worked on at a time; the
// next is accepted in the cycle after the previous result is loaded into
// the output register, even if it is still waiting there.
// Reset (synchronous, active low) restores the timeout to 600000 us, empties
// the ring, clears the average and drops both valids. If the receiver stalls,
// the output item is held and the block waits with its finished result.
`default_nettype none

module tachometer_period_to_rpm_average #(
    parameter int RING_DEPTH = tpra_pkg::RING_DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration: stall timeout in microseconds.
    input  wire logic                        i_cfg_we,
    input  wire logic [tpra_pkg::TIME_W-1:0] i_cfg_wdata,
    // Input stream.
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] current_time_us, [63:32] last_pulse_time_us,
    // [95:64] previous_pulse_time_us
    input  wire logic [95:0]                 i_s_tdata,
    // Output stream.
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [15:0] average_rpm, [31:16] instant_rpm
    output logic [31:0]                      o_m_tdata,
    // [0] stalled
    output logic                             o_m_tuser
);
    import tpra_pkg::*;

    // The running sum of the ring must hold RING_DEPTH full-scale entries.
    localparam int SUM_W = $clog2(RING_DEPTH * 65535 + 1);
    localparam int DIV_NUM_W = (SUM_W > RPM_NUM_W) ? SUM_W : RPM_NUM_W;

    t_state r_state;
    t_state n_state;

    logic [TIME_W-1:0] r_timeout;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] r_period;
    logic              r_stalled;
    logic [RPM_W-1:0]  r_inst;
    logic [RPM_W-1:0]  r_avg;
    logic [SUM_W-1:0]  r_sum;

    logic              r_out_valid;
    logic [RPM_W-1:0]  r_out_avg;
    logic [RPM_W-1:0]  r_out_inst;
    logic              r_out_stalled;

    // Control from the state machine.
    logic              w_in_ready;
    logic              w_div_start;
    logic              w_div_rpm;
    logic              w_ring_rd;
    logic              w_ring_wr;
    logic              w_out_load;
    logic              w_out_free;

    logic [DIV_NUM_W-1:0] w_div_num;
    logic [TIME_W-1:0]    w_div_den;
    logic [DIV_NUM_W-1:0] w_div_quot;
    t_div_status          w_div_status;
    logic [RPM_W-1:0]     w_ring_old;
    logic [RPM_W-1:0]     w_rpm_sat;
    logic                 w_accept;

    assign w_accept   = i_s_tvalid && w_in_ready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // The quotient of 60000000 / period saturates at full scale; periods
    // below 916 us land here.
    assign w_rpm_sat = (|w_div_quot[DIV_NUM_W-1:RPM_W]) ? RPM_MAX : w_div_quot[RPM_W-1:0];

    // One divider serves both the speed conversion and the averaging.
    assign w_div_num = w_div_rpm ? DIV_NUM_W'(RPM_NUMERATOR) : DIV_NUM_W'(r_sum);
    assign w_div_den = w_div_rpm ? r_period : TIME_W'(RING_DEPTH);

    tpra_div #(
        .NUM_W (DIV_NUM_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_div_num),
        .i_den    (w_div_den),
        .o_status (w_div_status),
        .o_quot   (w_div_quot)
    );

    tpra_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (w_ring_rd),
        .i_wr      (w_ring_wr),
        .i_wr_data (r_inst),
        .o_rd_data (w_ring_old)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                if (r_stalled || r_period == '0) begin
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                if (w_div_status.done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_ASTART;
            end
            S_ASTART: begin
                n_state = S_ADIV;
            end
            S_ADIV: begin
                if (w_div_status.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_div_rpm   = 1'b0;
        w_ring_rd   = 1'b0;
        w_ring_wr   = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_PREP: begin
                w_ring_rd = 1'b1;
            end
            S_SEL: begin
                w_div_rpm   = 1'b1;
                w_div_start = !r_stalled && (r_period != '0);
            end
            S_UPDATE: begin
                w_ring_wr = 1'b1;
            end
            S_ASTART: begin
                w_div_start = 1'b1;
            end
            S_OUT: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= STALL_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= i_s_tdata[31:0];
            r_last <= i_s_tdata[63:32];
            r_prev <= i_s_tdata[95:64];
        end
        if (r_state == S_PREP) begin
            r_period  <= r_last - r_prev;
            r_stalled <= (r_now - r_last) > r_timeout;
        end
        if (r_state == S_SEL) begin
            // A stall wins over a zero period, which keeps the last average.
            if (r_stalled) begin
                r_inst <= '0;
            end else if (r_period == '0) begin
                r_inst <= r_avg;
            end
        end
        if (r_state == S_QDIV && w_div_status.done) begin
            r_inst <= w_rpm_sat;
        end
    end

    // The ring sum is kept running: the entry being replaced leaves it and
    // the new instant speed joins it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_avg <= '0;
        end else begin
            if (w_ring_wr) begin
                r_sum <= r_sum - SUM_W'(w_ring_old) + SUM_W'(r_inst);
            end
            if (r_state == S_ADIV && w_div_status.done) begin
                r_avg <= w_div_quot[RPM_W-1:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_avg     <= r_avg;
            r_out_inst    <= r_inst;
            r_out_stalled <= r_stalled;
        end
    end

    assign o_s_tready = w_in_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_inst, r_out_avg};
    assign o_m_tuser  = r_out_stalled;

    a_stall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[31:16] == '0)
        else $error("stalled result with a non-zero instant speed");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_status.busy)
        else $error("divider started while busy");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sum) <= 32'(RING_DEPTH * 65535))
        else $error("ring sum beyond full scale");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_PREP)
        else $error("accepted item not taken into work");

endmodule

`default_nettype wire
